>>> rtl/core/skvt_pkg.sv
// shared opcodes, status codes and cell control type for the sorted key/value table
package skvt_pkg;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_FIND   = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_REPLACED  = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// broadcast command to every cell for the operation being committed
	typedef struct packed {
		logic ins;  // open a slot at the insert point, shift upper entries up
		logic rem;  // delete the matching entry, shift upper entries down
		logic rep;  // overwrite the value of the matching entry
	} skvt_ctrl_t;

endpackage

>>> rtl/core/skvt_cell.sv
// one slot of the sorted table: holds an entry, compares it, shifts with its neighbors
module skvt_cell
	import skvt_pkg::*;
#(
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  skvt_ctrl_t             ctrl,
	input  logic [KEY_WIDTH-1:0]   key,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic                   occupied,
	input  logic                   left_lt,
	input  logic [KEY_WIDTH-1:0]   left_key,
	input  logic [VALUE_WIDTH-1:0] left_value,
	input  logic [KEY_WIDTH-1:0]   right_key,
	input  logic [VALUE_WIDTH-1:0] right_value,
	output logic [KEY_WIDTH-1:0]   key_q,
	output logic [VALUE_WIDTH-1:0] value_q,
	output logic                   lt,
	output logic                   eq,
	output logic [VALUE_WIDTH-1:0] hit_value
);

	logic at_pos;

	assign lt        = occupied && (key_q < key);
	assign eq        = occupied && (key_q == key);
	assign at_pos    = !lt && left_lt;
	assign hit_value = eq ? value_q : '0;

	always_ff @(posedge clk) begin
		if (ctrl.ins && !lt) begin
			if (at_pos) begin
				key_q   <= key;
				value_q <= value;
			end else begin
				key_q   <= left_key;
				value_q <= left_value;
			end
		end else if (ctrl.rem && !lt) begin
			key_q   <= right_key;
			value_q <= right_value;
		end else if (ctrl.rep && eq) begin
			value_q <= value;
		end
	end

endmodule

>>> rtl/core/sorted_key_value_table.sv
// top level of the sorted key/value table: input register, cell row and result register
//
// The table keeps up to CAPACITY key/value entries in ascending unsigned key
// order in a row of cells; cell i holds slot i and slots below the entry
// count are live. An operation is taken into an input register, and in the
// next cycle its key is broadcast to every cell: each cell compares its key
// in parallel, the cells work out the insert or remove point locally from
// their own and their left neighbor's compare, and the whole row shifts by
// one slot when the operation commits, as the result lands in the output register.
// One operation per cycle is sustained while the output does not stall; the
// result is registered; the parallel compare-and-shift across the row sets the rate.
// The input stalls only while an operation waits on a stalled output. Insert
// of a present key replaces its value even when the table is full; insert of
// a new key into a full table reports full; opcode 3 reports not found.
module sorted_key_value_table
	import skvt_pkg::*;
#(
	parameter int CAPACITY    = 64,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         opcode,
	input  logic [KEY_WIDTH-1:0]               key,
	input  logic [VALUE_WIDTH-1:0]             value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         status,
	output logic [VALUE_WIDTH-1:0]             found_value,
	output logic [$clog2(CAPACITY+1)-1:0]      entry_count
);

	localparam int CW = $clog2(CAPACITY + 1);

	// input register stage
	logic                   valid_s1;
	logic [1:0]             op_s1;
	logic [KEY_WIDTH-1:0]   key_s1;
	logic [VALUE_WIDTH-1:0] value_s1;

	// table state
	logic [CW-1:0] count_q;

	// result register
	logic                   out_valid_q;
	logic [1:0]             status_q;
	logic [VALUE_WIDTH-1:0] found_value_q;
	logic [CW-1:0]          entry_count_q;

	// cell row wiring
	logic [KEY_WIDTH-1:0]   cell_key   [CAPACITY];
	logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
	logic [VALUE_WIDTH-1:0] cell_hit   [CAPACITY];
	logic [CAPACITY-1:0]    lt_vec;
	logic [CAPACITY-1:0]    eq_vec;

	logic                   out_free;
	logic                   advance;
	logic                   in_xfer;
	logic                   hit;
	logic                   full;
	logic [VALUE_WIDTH-1:0] hit_value;
	skvt_ctrl_t             ctrl;
	logic [1:0]             status_d;
	logic [CW-1:0]          count_d;

	// output register is free when empty or its transfer completes this cycle
	assign out_free = !out_valid_q || !out_stall;
	// the staged operation commits when its result can be registered
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_xfer  = in_valid && !in_stall;

	assign hit  = |eq_vec;
	assign full = (count_q == CW'(CAPACITY));

	// matching cell drives its value, all others give zero
	always_comb begin
		hit_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit_value = hit_value | cell_hit[i];
		end
	end

	// commit command and result for the staged operation
	always_comb begin
		ctrl     = '0;
		status_d = ST_NOT_FOUND;
		count_d  = count_q;
		case (op_s1)
			OP_INSERT: begin
				if (hit) begin
					ctrl.rep = advance;
					status_d = ST_REPLACED;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					ctrl.ins = advance;
					status_d = ST_OK;
					count_d  = count_q + CW'(1);
				end
			end
			OP_FIND: begin
				if (hit) begin
					status_d = ST_OK;
				end
			end
			OP_REMOVE: begin
				if (hit) begin
					ctrl.rem = advance;
					status_d = ST_OK;
					count_d  = count_q - CW'(1);
				end
			end
			default: begin
				status_d = ST_NOT_FOUND;
			end
		endcase
	end

	// row of cells; slot 0 sees a "left is less" so it can take the insert point
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                   left_lt;
		logic [KEY_WIDTH-1:0]   left_key;
		logic [VALUE_WIDTH-1:0] left_value;
		logic [KEY_WIDTH-1:0]   right_key;
		logic [VALUE_WIDTH-1:0] right_value;

		if (i == 0) begin : g_first
			assign left_lt    = 1'b1;
			assign left_key   = key_s1;
			assign left_value = value_s1;
		end else begin : g_mid
			assign left_lt    = lt_vec[i-1];
			assign left_key   = cell_key[i-1];
			assign left_value = cell_value[i-1];
		end

		// the top slot has nothing above it; what it takes on remove is dead
		if (i == CAPACITY - 1) begin : g_last
			assign right_key   = cell_key[i];
			assign right_value = cell_value[i];
		end else begin : g_below
			assign right_key   = cell_key[i+1];
			assign right_value = cell_value[i+1];
		end

		skvt_cell #(
			.KEY_WIDTH  (KEY_WIDTH),
			.VALUE_WIDTH(VALUE_WIDTH)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.key        (key_s1),
			.value      (value_s1),
			.occupied   (count_q > CW'(i)),
			.left_lt    (left_lt),
			.left_key   (left_key),
			.left_value (left_value),
			.right_key  (right_key),
			.right_value(right_value),
			.key_q      (cell_key[i]),
			.value_q    (cell_value[i]),
			.lt         (lt_vec[i]),
			.eq         (eq_vec[i]),
			.hit_value  (cell_hit[i])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				count_q     <= count_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1    <= opcode;
			key_s1   <= key;
			value_s1 <= value;
		end
		if (advance) begin
			status_q      <= status_d;
			found_value_q <= (op_s1 == OP_FIND) ? hit_value : '0;
			entry_count_q <= count_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_value = found_value_q;
	assign entry_count = entry_count_q;

	// keys are unique, so at most one cell may match
	a_unique_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0(eq_vec))
		else $error("more than one cell matches the key");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(count_q))
		else $error("entry count changed without a committed operation");

	a_value_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && found_value_q != '0) |-> (status_q == ST_OK))
		else $error("found value given with a status other than ok");

endmodule
